// ----- hw/rtl/esdm_pkg.sv -----
`timescale 1ns / 1ps

package esdm_pkg;

  // timestamp width, edge intervals wrap modulo 2^TIME_WIDTH (16 to 64)
  localparam int TIME_WIDTH = 48;
  localparam int CMP_WIDTH  = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

  localparam int THRESH_WIDTH  = 32;
  localparam int SCALE_WIDTH   = 16;
  localparam int NUMER_WIDTH   = 31;
  localparam int CONFIRM_WIDTH = 3;
  localparam int COUNT_WIDTH   = 32;
  localparam int CHANGE_WIDTH  = 4;
  localparam int PROD_WIDTH    = COUNT_WIDTH + SCALE_WIDTH;
  localparam int SPEED_WIDTH   = 32;
  localparam int MAG_WIDTH     = SPEED_WIDTH - 1;

  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 32;

  // one quotient bit per step, quotient never wider than the numerator
  localparam int DIV_STEPS  = NUMER_WIDTH;
  localparam int STEP_WIDTH = $clog2(DIV_STEPS);

  localparam logic [THRESH_WIDTH-1:0]  RESET_THRESHOLD = 32'd5000000;
  localparam logic [SCALE_WIDTH-1:0]   RESET_SCALE     = 16'd100;
  localparam logic [NUMER_WIDTH-1:0]   RESET_NUMERATOR = 31'd2000000000;
  localparam logic [CONFIRM_WIDTH-1:0] RESET_CONFIRM   = 3'd3;
  localparam logic [CHANGE_WIDTH-1:0]  CHANGE_MAX      = '1;
  localparam logic [COUNT_WIDTH-1:0]   COUNT_MAX       = '1;
  localparam logic [MAG_WIDTH-1:0]     MAG_MAX         = '1;

  typedef enum logic {
    CMD_EDGE   = 1'b0,
    CMD_WINDOW = 1'b1
  } cmd_code_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_PERIOD_THRESHOLD = 2'd0,
    REG_COUNT_SCALE      = 2'd1,
    REG_PERIOD_NUMERATOR = 2'd2,
    REG_DIRECTION_CONFIRM = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept_edge;
    logic accept_window;
    logic div_step;
    logic load_result;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_needed;
    logic out_free;
  } dp_status_t;

endpackage

// ----- hw/rtl/esdm_ifs.sv -----
`timescale 1ns / 1ps

interface esdm_item_if;
  import esdm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  command;
  logic                  phase_b_level;
  logic [TIME_WIDTH-1:0] edge_time;

  modport source (output valid, command, phase_b_level, edge_time, input ready);
  modport sink (input valid, command, phase_b_level, edge_time, output ready);
endinterface

interface esdm_result_if;
  import esdm_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SPEED_WIDTH-1:0] speed_millihertz;
  logic                          used_period_mode;

  modport source (output valid, speed_millihertz, used_period_mode, input ready);
  modport sink (input valid, speed_millihertz, used_period_mode, output ready);
endinterface

interface esdm_cfg_if;
  import esdm_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [CFG_INDEX_WIDTH-1:0] index;
  logic [CFG_DATA_WIDTH-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/esdm_ctrl.sv -----
`timescale 1ns / 1ps

module esdm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_command,
  output logic                 in_ready,
  input  esdm_pkg::dp_status_t status,
  output esdm_pkg::dp_cmd_t    cmd
);
  import esdm_pkg::*;

  state_t                state;
  state_t                state_next;
  logic [STEP_WIDTH-1:0] steps;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      steps <= '0;
    end else begin
      state <= state_next;
      if (cmd.accept_window) begin
        steps <= STEP_WIDTH'(DIV_STEPS - 1);
      end else if (cmd.div_step) begin
        steps <= steps - 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && (in_command == CMD_WINDOW)) begin
          state_next = status.div_needed ? ST_DIVIDE : ST_FINISH;
        end
      end
      ST_DIVIDE: begin
        if (steps == '0) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready          = 1'b1;
        cmd.accept_edge   = in_valid && (in_command == CMD_EDGE);
        cmd.accept_window = in_valid && (in_command == CMD_WINDOW);
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
      end
      ST_FINISH: begin
        cmd.load_result = status.out_free;
      end
      default: ;
    endcase
  end

endmodule

// ----- hw/rtl/esdm_datapath.sv -----
`timescale 1ns / 1ps

module esdm_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            phase_b_level,
  input  logic [esdm_pkg::TIME_WIDTH-1:0] edge_time,
  input  esdm_pkg::dp_cmd_t               cmd,
  output esdm_pkg::dp_status_t            status,
  esdm_cfg_if.sink                        cfg,
  esdm_result_if.source                   result
);
  import esdm_pkg::*;

  // configuration
  logic [THRESH_WIDTH-1:0]  period_threshold;
  logic [SCALE_WIDTH-1:0]   count_scale;
  logic [NUMER_WIDTH-1:0]   period_numerator;
  logic [CONFIRM_WIDTH-1:0] direction_confirm;

  // measurement state
  logic [TIME_WIDTH-1:0]   last_edge_time;
  logic [TIME_WIDTH-1:0]   edge_interval;
  logic [COUNT_WIDTH-1:0]  edge_count;
  logic                    period_mode;
  logic                    direction;
  logic                    previous_level;
  logic [CHANGE_WIDTH-1:0] change_count;

  // window work registers
  logic                   win_period;
  logic                   win_direction;
  logic [PROD_WIDTH-1:0]  prod;
  logic [TIME_WIDTH-1:0]  rem;
  logic [TIME_WIDTH-1:0]  divisor;
  logic [NUMER_WIDTH-1:0] dividend;
  logic [NUMER_WIDTH-1:0] quo;

  // output register
  logic                          res_valid;
  logic signed [SPEED_WIDTH-1:0] res_speed;
  logic                          res_mode;

  logic [CHANGE_WIDTH-1:0] change_next;
  logic                    flip;
  logic [TIME_WIDTH-1:0]   interval_next;
  logic [TIME_WIDTH:0]     trial;
  logic [MAG_WIDTH-1:0]    mag;
  logic [SPEED_WIDTH-1:0]  speed_pos;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_threshold  <= RESET_THRESHOLD;
      count_scale       <= RESET_SCALE;
      period_numerator  <= RESET_NUMERATOR;
      direction_confirm <= RESET_CONFIRM;
    end else if (cfg.valid) begin
      unique case (reg_index_t'(cfg.index))
        REG_PERIOD_THRESHOLD:  period_threshold  <= cfg.data[THRESH_WIDTH-1:0];
        REG_COUNT_SCALE:       count_scale       <= cfg.data[SCALE_WIDTH-1:0];
        REG_PERIOD_NUMERATOR:  period_numerator  <= cfg.data[NUMER_WIDTH-1:0];
        REG_DIRECTION_CONFIRM: direction_confirm <= cfg.data[CONFIRM_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // direction qualifier
  always_comb begin
    change_next = change_count;
    if ((phase_b_level != direction) && (phase_b_level == previous_level)
        && (change_count != CHANGE_MAX)) begin
      change_next = change_count + 1'b1;
    end
    if (phase_b_level != previous_level) begin
      change_next = '0;
    end
    flip = change_next > CHANGE_WIDTH'(direction_confirm);
  end

  assign interval_next = edge_time - last_edge_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_edge_time <= '0;
      edge_interval  <= '0;
      edge_count     <= '0;
      period_mode    <= 1'b0;
      direction      <= 1'b1;
      previous_level <= 1'b1;
      change_count   <= '0;
    end else if (cmd.accept_edge) begin
      if (flip) begin
        direction    <= phase_b_level;
        change_count <= '0;
      end else begin
        change_count <= change_next;
      end
      previous_level <= phase_b_level;
      if (edge_count != COUNT_MAX) begin
        edge_count <= edge_count + 1'b1;
      end
      edge_interval  <= interval_next;
      period_mode    <= CMP_WIDTH'(interval_next) > CMP_WIDTH'(period_threshold);
      last_edge_time <= edge_time;
    end else if (cmd.accept_window) begin
      edge_count    <= '0;
      edge_interval <= '0;
    end
  end

  assign status.div_needed = period_mode && (edge_interval != '0);
  assign status.out_free   = !res_valid || result.ready;

  // restoring division, one quotient bit per step
  assign trial = {rem, dividend[NUMER_WIDTH-1]} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (cmd.accept_window) begin
      win_period    <= period_mode;
      win_direction <= direction;
      prod          <= PROD_WIDTH'(edge_count) * PROD_WIDTH'(count_scale);
      rem           <= '0;
      divisor       <= edge_interval;
      dividend      <= period_numerator;
      quo           <= '0;
    end else if (cmd.div_step) begin
      dividend <= dividend << 1;
      if (!trial[TIME_WIDTH]) begin
        rem <= trial[TIME_WIDTH-1:0];
        quo <= {quo[NUMER_WIDTH-2:0], 1'b1};
      end else begin
        rem <= {rem[TIME_WIDTH-2:0], dividend[NUMER_WIDTH-1]};
        quo <= {quo[NUMER_WIDTH-2:0], 1'b0};
      end
    end
  end

  // saturate, then apply the direction
  always_comb begin
    if (win_period) begin
      mag = quo;
    end else if (prod > PROD_WIDTH'(MAG_MAX)) begin
      mag = MAG_MAX;
    end else begin
      mag = prod[MAG_WIDTH-1:0];
    end
    speed_pos = {1'b0, mag};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load_result) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      res_speed <= win_direction ? signed'(speed_pos) : signed'(-speed_pos);
      res_mode  <= win_period;
    end
  end

  assign result.valid            = res_valid;
  assign result.speed_millihertz = res_speed;
  assign result.used_period_mode = res_mode;

endmodule

// ----- hw/rtl/encoder_speed_direction_meter_top.sv -----
`timescale 1ns / 1ps

// channel  role    payload
// item     sink    command, phase_b_level, edge_time
// result   source  speed_millihertz, used_period_mode
// cfg      sink    index, data (always ready)
//
// an edge item is taken straight from idle; a window item goes through load and
// finish in count mode or with a zero interval, and through load, 31 restoring
// divide steps and finish in period mode; results wait in an output register,
// so new items are taken while a result is pending, and a window item stalls
// in finish only while the output register is still full;
// rst is synchronous and restores the register defaults and the measurement state

module encoder_speed_direction_meter_top (
  input  logic          clk,
  input  logic          rst,
  esdm_item_if.sink     item,
  esdm_result_if.source result,
  esdm_cfg_if.sink      cfg
);
  import esdm_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer: idle, divide steps, result hand-off
  esdm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (item.valid),
    .in_command (item.command),
    .in_ready   (item.ready),
    .status     (status),
    .cmd        (cmd)
  );

  // qualifier, counters, multiplier, divider, output register
  esdm_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .phase_b_level (item.phase_b_level),
    .edge_time     (item.edge_time),
    .cmd           (cmd),
    .status        (status),
    .cfg           (cfg),
    .result        (result)
  );

endmodule

// ----- tb/encoder_speed_direction_meter_top_tb.sv -----
`timescale 1ns / 1ps

module encoder_speed_direction_meter_top_tb;
  import esdm_pkg::*;

  // cycles allowed after the last result before touching registers or ending:
  // a period-mode window needs load, 31 divide steps and finish
  localparam int SETTLE_CYCLES = 48;
  // random items per handshake phase
  localparam int PHASE_ITEMS = 390;

  // one expected window result
  typedef struct packed {
    logic signed [SPEED_WIDTH-1:0] speed;
    logic                          period;
  } speed_due_t;

  // tracks the meter state, predicts each window speed and checks it
  class speed_scoreboard;
    logic [THRESH_WIDTH-1:0]  threshold;
    logic [SCALE_WIDTH-1:0]   scale;
    logic [NUMER_WIDTH-1:0]   numerator;
    logic [CONFIRM_WIDTH-1:0] confirm;

    logic [TIME_WIDTH-1:0]    last_time;
    logic [TIME_WIDTH-1:0]    interval;
    logic [COUNT_WIDTH-1:0]   edge_total;
    logic                     period_sel;
    logic                     dir_fwd;
    logic                     prev_level;
    logic [CHANGE_WIDTH-1:0]  settle_count;

    speed_due_t speed_due[$];
    int errors, edges, windows, turns, period_results, saturated;

    function new();
      threshold    = RESET_THRESHOLD;
      scale        = RESET_SCALE;
      numerator    = RESET_NUMERATOR;
      confirm      = RESET_CONFIRM;
      last_time    = '0;
      interval     = '0;
      edge_total   = '0;
      period_sel   = 1'b0;
      dir_fwd      = 1'b1;
      prev_level   = 1'b1;
      settle_count = '0;
    endfunction

    function void write_reg(reg_index_t idx, logic [CFG_DATA_WIDTH-1:0] data);
      case (idx)
        REG_PERIOD_THRESHOLD:  threshold = data[THRESH_WIDTH-1:0];
        REG_COUNT_SCALE:       scale     = data[SCALE_WIDTH-1:0];
        REG_PERIOD_NUMERATOR:  numerator = data[NUMER_WIDTH-1:0];
        REG_DIRECTION_CONFIRM: confirm   = data[CONFIRM_WIDTH-1:0];
        default: ;
      endcase
    endfunction

    function void note_item(cmd_code_t cmd, logic level, logic [TIME_WIDTH-1:0] stamp);
      logic [63:0] mag;
      logic [63:0] num_wide;
      logic [63:0] int_wide;
      speed_due_t  due;
      if (cmd == CMD_EDGE) begin
        edges++;
        // direction qualifier: steady differing edges build up, a flip resets
        if (level != dir_fwd && prev_level == level && settle_count != CHANGE_MAX)
          settle_count++;
        if (prev_level != level)
          settle_count = '0;
        if (settle_count > confirm) begin
          if (dir_fwd != level) turns++;
          dir_fwd      = level;
          settle_count = '0;
        end
        prev_level = level;
        if (edge_total != COUNT_MAX)
          edge_total++;
        interval   = stamp - last_time;
        period_sel = (interval > threshold);
        last_time  = stamp;
      end else begin
        windows++;
        num_wide = 64'(numerator);
        int_wide = 64'(interval);
        if (period_sel)
          mag = (int_wide != 0) ? num_wide / int_wide : 64'd0;
        else
          mag = 64'(edge_total) * 64'(scale);
        if (mag > 64'(MAG_MAX)) begin
          mag = 64'(MAG_MAX);
          saturated++;
        end
        due.speed  = dir_fwd ? mag[SPEED_WIDTH-1:0] : -mag[SPEED_WIDTH-1:0];
        due.period = period_sel;
        if (period_sel) period_results++;
        speed_due.push_back(due);
        interval   = '0;
        edge_total = '0;
      end
    endfunction

    function void flag(string field, longint want, longint got);
      errors++;
      if (errors <= 30)
        $display("%0t mismatch %s: expected %0d actual %0d", $time, field, want, got);
    endfunction

    function void check_result(logic signed [SPEED_WIDTH-1:0] speed, logic period);
      speed_due_t want;
      if (speed_due.size() == 0) begin
        errors++;
        if (errors <= 30)
          $display("%0t result with nothing pending: expected none actual speed %0d mode %0d",
                   $time, speed, period);
      end else begin
        want = speed_due.pop_front();
        if (want.speed !== speed) flag("speed_millihertz", want.speed, speed);
        if (want.period !== period) flag("used_period_mode", want.period, period);
      end
    endfunction

    function int pending();
      return speed_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  esdm_item_if   item_ch();
  esdm_result_if result_ch();
  esdm_cfg_if    cfg_ch();

  encoder_speed_direction_meter_top dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  speed_scoreboard meter;

  // idle and stall odds in percent, changed per phase
  int send_idle_pct;
  int stall_pct;

  // running encoder time and the current steady run of channel B
  logic [TIME_WIDTH-1:0] cur_time;
  logic                  run_level;
  int                    run_left;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result side: check on every accepted result, then pick next ready
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        meter.check_result(result_ch.speed_millihertz, result_ch.used_period_mode);
      result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // present one item, possibly after a random idle gap, and wait for it to go in;
  // valid stays high after acceptance so back-to-back items need no second write
  task automatic send_item(cmd_code_t cmd, logic level, logic [TIME_WIDTH-1:0] stamp);
    int gap;
    gap = 0;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct && gap < 24)
      gap++;
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid         <= 1'b1;
    item_ch.command       <= cmd;
    item_ch.phase_b_level <= level;
    item_ch.edge_time     <= stamp;
    @(posedge clk);
    while (item_ch.ready !== 1'b1) @(posedge clk);
    meter.note_item(cmd, level, stamp);
  endtask

  // write all four registers back to back; unused upper data bits get noise
  task automatic program_regs(logic [THRESH_WIDTH-1:0] thr, logic [SCALE_WIDTH-1:0] sc,
                              logic [NUMER_WIDTH-1:0] num, logic [CONFIRM_WIDTH-1:0] conf);
    reg_index_t                idx;
    logic [CFG_DATA_WIDTH-1:0] data;
    for (int i = 0; i < 4; i++) begin
      idx = reg_index_t'(i);
      case (idx)
        REG_PERIOD_THRESHOLD:  data = thr;
        REG_COUNT_SCALE:       data = sc | ($urandom & 32'hFFFF_0000);
        REG_PERIOD_NUMERATOR:  data = num | ($urandom & 32'h8000_0000);
        REG_DIRECTION_CONFIRM: data = conf | ($urandom & 32'hFFFF_FFF8);
        default:               data = '0;
      endcase
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx;
      cfg_ch.data  <= data;
      @(posedge clk);
      while (cfg_ch.ready !== 1'b1) @(posedge clk);
      meter.write_reg(idx, data);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // wait for every pending window result, then let the divider run out
  task automatic settle();
    while (meter.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly edge bursts closed by a window, with steady channel B runs so the
  // qualifier actually turns; the rest is loose items with random content
  task automatic run_traffic(int n_items);
    int                    sent;
    int                    burst;
    logic [TIME_WIDTH-1:0] delta;
    logic [63:0]           wide;
    logic                  lvl;
    cmd_code_t             cmd;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 75) begin
        // zero edges gives a window right after a window
        burst = $urandom_range(8);
        for (int k = 0; k < burst; k++) begin
          if (run_left == 0) begin
            run_level = 1'($urandom_range(1));
            run_left  = $urandom_range(12, 1);
          end
          run_left--;
          // occasional glitch against the run
          lvl = ($urandom_range(9) == 0) ? ~run_level : run_level;
          wide = {$urandom, $urandom};
          // intervals around the threshold, zero, tiny, huge and wrapping
          case ($urandom_range(9))
            0:       delta = '0;
            1, 2, 3: delta = TIME_WIDTH'($urandom_range(meter.threshold));
            4:       delta = TIME_WIDTH'(meter.threshold);
            5:       delta = {16'd0, meter.threshold} + 48'd1;
            6, 7:    delta = wide[TIME_WIDTH-1:0];
            8:       delta = TIME_WIDTH'($urandom_range(1000, 1));
            default: delta = '1 - TIME_WIDTH'($urandom_range(1000));
          endcase
          cur_time += delta;
          send_item(CMD_EDGE, lvl, cur_time);
        end
        // window fields other than the command must not matter
        wide = {$urandom, $urandom};
        send_item(CMD_WINDOW, 1'($urandom_range(1)), wide[TIME_WIDTH-1:0]);
        sent += burst + 1;
      end else begin
        wide = {$urandom, $urandom};
        cmd  = cmd_code_t'($urandom_range(1));
        if (cmd == CMD_EDGE) cur_time = wide[TIME_WIDTH-1:0];
        send_item(cmd, 1'($urandom_range(1)), wide[TIME_WIDTH-1:0]);
        sent++;
      end
    end
    item_ch.valid <= 1'b0;
  endtask

  initial begin
    meter = new();
    send_idle_pct         = 0;
    stall_pct             = 0;
    cur_time              = '0;
    run_level             = 1'b1;
    run_left              = 0;
    rst                   = 1'b1;
    item_ch.valid         = 1'b0;
    item_ch.command       = CMD_EDGE;
    item_ch.phase_b_level = 1'b0;
    item_ch.edge_time     = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = REG_PERIOD_THRESHOLD;
    cfg_ch.data           = '0;
    result_ch.ready       = 1'b0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed part at reset register values
    // windows straight out of reset report zero; ignored fields at extremes
    send_item(CMD_WINDOW, 1'b0, '0);
    send_item(CMD_WINDOW, 1'b1, '1);
    // two short edges in count mode, still forward
    send_item(CMD_EDGE, 1'b1, 48'd1000);
    send_item(CMD_EDGE, 1'b1, 48'd2000);
    send_item(CMD_WINDOW, 1'b0, '0);
    // five steady low edges exceed the confirm count and turn to reverse,
    // and the long intervals select period mode
    for (int i = 1; i <= 5; i++)
      send_item(CMD_EDGE, 1'b0, 48'd2000 + 48'(i) * 48'd10_000_000);
    send_item(CMD_WINDOW, 1'b0, '0);
    // period mode survives the window but the interval is now zero
    send_item(CMD_WINDOW, 1'b1, '0);
    // timestamp wrap, zero interval with a level glitch, interval equal to threshold
    send_item(CMD_EDGE, 1'b0, 48'hFFFF_FFFF_FFF0);
    send_item(CMD_EDGE, 1'b0, 48'h10);
    send_item(CMD_EDGE, 1'b1, 48'h10);
    send_item(CMD_EDGE, 1'b0, 48'h10 + 48'd5_000_000);
    send_item(CMD_WINDOW, 1'b0, '0);
    // huge interval makes the quotient zero
    send_item(CMD_EDGE, 1'b1, '1);
    send_item(CMD_WINDOW, 1'b0, '0);
    item_ch.valid <= 1'b0;
    settle();

    // random phases, one handshake mix and one register setting each
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
          program_regs(32'd5000, 16'hFFFF, 31'h7FFF_FFFF, 3'd0);
        end
        1: begin
          send_idle_pct = 65;
          stall_pct     = 0;
          program_regs(32'd0, 16'd0, 31'd0, 3'd7);
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 65;
          program_regs(32'hFFFF_FFFF, 16'd1, NUMER_WIDTH'($urandom), 3'($urandom));
        end
        default: begin
          send_idle_pct = 15;
          stall_pct     = 15;
          program_regs($urandom_range(100_000_000, 1000), SCALE_WIDTH'($urandom),
                       NUMER_WIDTH'($urandom), 3'($urandom));
        end
      endcase
      run_traffic(PHASE_ITEMS);
      settle();
    end

    $display("covered %0d edge items and %0d window results (%0d period, %0d saturated)",
             meter.edges, meter.windows, meter.period_results, meter.saturated);
    $display("direction turned %0d times across four handshake mixes", meter.turns);
    if (meter.errors == 0 && meter.pending() == 0)
      $display("** encoder_speed_direction_meter_top: PASSED **");
    else
      $display("** encoder_speed_direction_meter_top: FAILED **");
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", meter.pending());
    $display("** encoder_speed_direction_meter_top: FAILED **");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/esdm_pkg.sv
hw/rtl/esdm_ifs.sv
hw/rtl/esdm_ctrl.sv
hw/rtl/esdm_datapath.sv
hw/rtl/encoder_speed_direction_meter_top.sv
tb/encoder_speed_direction_meter_top_tb.sv
